### hw/rtl/bprf_pkg.sv
// Shared types and constants of the band-pass row filter.
package bprf_pkg;

  localparam int PIX_W      = 8;
  localparam int OUTER_W    = 6;
  localparam int INNER_W    = 5;
  localparam int GAIN_W     = 4;
  localparam int SHIFT_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int POS_W      = 16;

  localparam int NUM_TAPS   = 8;
  localparam int NUM_BANKS  = NUM_TAPS / 2;
  localparam int TAP_SUM_W  = 12;
  localparam int DSUM_W     = 16;

  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;
  localparam int Q_CW       = 3;

  localparam int MIN_OUTER  = 2;

  localparam logic [OUTER_W-1:0] OUTER_RST = 6'd16;
  localparam logic [INNER_W-1:0] INNER_RST = 5'd8;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 4'd8;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 6'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTER = 2'd0,
    CFG_INNER = 2'd1,
    CFG_GAIN  = 2'd2,
    CFG_SHIFT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic emit;
    logic last;
  } step_ctl_t;

endpackage

### hw/rtl/bprf_window.sv
// Pixel window memory, tap fetch and tap sum of the band-pass row filter.
module bprf_window import bprf_pkg::*; #(
  parameter int WINDOW_DEPTH = 64,
  parameter int OUTER_CAP = 32,
  localparam int AW = $clog2(WINDOW_DEPTH),
  localparam int OW = $clog2(OUTER_CAP + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [PIX_W-1:0]         wr_data_i,
  input  logic                     iss_valid_i,
  input  step_ctl_t                iss_ctl_i,
  input  logic [POS_W:0]           iss_pos_i,
  input  logic [AW-1:0]            iss_ptr_i,
  input  logic [OW-1:0]            iss_ahead_i,
  input  logic [PIX_W-1:0]         iss_pix_i,
  input  logic [OW-1:0]            outer_i,
  input  logic [INNER_W-1:0]       inner_i,
  input  logic [GAIN_W-1:0]        gain_i,
  output logic                     res_valid_o,
  output step_ctl_t                res_ctl_o,
  output logic signed [DSUM_W-1:0] res_sum_o
);

  localparam int DW = $clog2(2 * OUTER_CAP + 1);

  logic [PIX_W-1:0] win_mem [NUM_BANKS][WINDOW_DEPTH];

  logic [OW-1:0]      half_o;
  logic [INNER_W-1:0] half_i;
  logic [DW-1:0]      dly [NUM_TAPS];
  logic [AW:0]        diff [1:NUM_TAPS-1];
  logic [AW-1:0]      raddr [1:NUM_TAPS-1];
  logic [NUM_TAPS-1:0] tap_ok;

  logic [PIX_W-1:0]    rd_q [1:NUM_TAPS-1];
  logic                s1_v_q;
  step_ctl_t           s1_ctl_q;
  logic [NUM_TAPS-1:0] s1_ok_q;
  logic [PIX_W-1:0]    s1_pix_q;

  logic signed [TAP_SUM_W-1:0] tap_val [NUM_TAPS];
  logic signed [TAP_SUM_W-1:0] wide;
  logic signed [TAP_SUM_W-1:0] narrow;
  logic signed [DSUM_W-1:0]    narrow_x;
  logic signed [DSUM_W-1:0]    gain_x;
  logic signed [DSUM_W-1:0]    sum_d;

  logic                     s2_v_q;
  step_ctl_t                s2_ctl_q;
  logic signed [DSUM_W-1:0] s2_sum_q;

  always_comb begin
    half_o = outer_i >> 1;
    half_i = inner_i >> 1;
    dly[0] = '0;
    dly[1] = DW'(outer_i) - DW'(half_o);
    dly[2] = DW'(outer_i) + DW'(half_o);
    dly[3] = DW'(outer_i) + DW'(outer_i);
    dly[4] = DW'(outer_i) - DW'(inner_i);
    dly[5] = DW'(outer_i) - DW'(half_i);
    dly[6] = DW'(outer_i) + DW'(half_i);
    dly[7] = DW'(outer_i) + DW'(inner_i);
    for (int k = 0; k < NUM_TAPS; k++) begin
      tap_ok[k] = (iss_pos_i >= (POS_W + 1)'(dly[k])) && (dly[k] >= DW'(iss_ahead_i));
    end
    for (int k = 1; k < NUM_TAPS; k++) begin
      diff[k] = (AW + 1)'(iss_ptr_i) - (AW + 1)'(dly[k]);
      if (diff[k][AW]) begin
        raddr[k] = AW'(diff[k] + (AW + 1)'(WINDOW_DEPTH));
      end else begin
        raddr[k] = AW'(diff[k]);
      end
    end
  end

  // Read-first: a tap one full window back sees the old entry.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        win_mem[b][wr_addr_i] <= wr_data_i;
      end
    end
    for (int k = 1; k < NUM_TAPS; k++) begin
      rd_q[k] <= win_mem[(k - 1) >> 1][raddr[k]];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctl_q <= iss_ctl_i;
    s1_ok_q  <= tap_ok;
    s1_pix_q <= iss_pix_i;
  end

  always_comb begin
    tap_val[0] = s1_ok_q[0] ? TAP_SUM_W'(s1_pix_q) : '0;
    for (int k = 1; k < NUM_TAPS; k++) begin
      tap_val[k] = s1_ok_q[k] ? TAP_SUM_W'(rd_q[k]) : '0;
    end
    wide   = (tap_val[1] <<< 1) - (tap_val[2] <<< 1) + tap_val[3] - tap_val[0];
    narrow = tap_val[4] - (tap_val[5] <<< 1) + (tap_val[6] <<< 1) - tap_val[7];
    narrow_x = DSUM_W'(narrow);
    gain_x   = DSUM_W'({1'b0, gain_i});
    sum_d    = DSUM_W'(wide) + narrow_x * gain_x;
  end

  always_ff @(posedge clk_i) begin
    s2_ctl_q <= s1_ctl_q;
    s2_sum_q <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= iss_valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  assign res_valid_o = s2_v_q;
  assign res_ctl_o   = s2_ctl_q;
  assign res_sum_o   = s2_sum_q;

endmodule

### hw/rtl/band_pass_row_filter.sv
// Top level of the band-pass row filter: sequencer, accumulators and result queue.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i, in_stall_o   | pixel_in_i, row_end_i
//   out     | output    | out_valid_o, out_stall_i | pixel_out_o, row_last_o
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One pixel a cycle while in_stall_o is low; a row-end pixel then stalls the input
// while the flush steps, one per unit of the effective outer span (up to 32), go
// through the window. A result is registered in the window read, the tap sum and
// the result queue before it leaves.
// Reset clears accumulators, position and pointers and sets the config defaults;
// the window is not cleared. Output stalls fill a four-entry result queue; the
// input stalls when the steps in flight could overrun it.
module band_pass_row_filter import bprf_pkg::*; #(
  parameter int MAX_OUTER = 32,
  parameter int WINDOW_DEPTH = 64,
  parameter int ACC_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      pixel_in_i,
  input  logic                  row_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic                  row_last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int OUTER_CAP = (MAX_OUTER < WINDOW_DEPTH / 2) ? MAX_OUTER : WINDOW_DEPTH / 2;
  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int OW = $clog2(OUTER_CAP + 1);
  localparam int CW = ((OW > INNER_W) ? OW : INNER_W) + 1;
  localparam int FOLD_BASE = 65536 - WINDOW_DEPTH * (32768 / WINDOW_DEPTH);

  logic [OUTER_W-1:0] outer_q;
  logic [INNER_W-1:0] inner_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [SHIFT_W-1:0] shift_q;

  logic [OW-1:0]      o_eff;
  logic [CW-1:0]      o_less;
  logic [INNER_W-1:0] i_eff;

  logic [POS_W-1:0] cnt_q;
  logic [AW-1:0]    wp_q;
  logic [AW-1:0]    wp_nx;
  logic             flush_q;
  logic [OW-1:0]    fj_q;
  logic [POS_W:0]   fm_q;
  logic [AW-1:0]    fsp_q;
  logic [AW-1:0]    fsp_nx;
  logic             iss_q;

  logic             can_issue;
  logic             acc;
  logic             iss_v;
  step_ctl_t        iss_ctl;
  logic [POS_W:0]   iss_pos;
  logic [AW-1:0]    iss_ptr;
  logic [OW-1:0]    iss_ahead;
  logic [PIX_W-1:0] iss_pix;

  logic                     res_v;
  step_ctl_t                res_ctl;
  logic signed [DSUM_W-1:0] res_sum;

  logic [ACC_WIDTH-1:0]        lvl_q;
  logic [ACC_WIDTH-1:0]        slope_q;
  logic [ACC_WIDTH-1:0]        curve_q;
  logic signed [ACC_WIDTH-1:0] lvl_sh;
  logic [PIX_W-1:0]            sat;

  logic [PIX_W-1:0] q_pix_q [Q_DEPTH];
  logic             q_last_q [Q_DEPTH];
  logic [Q_AW-1:0]  q_wp_q;
  logic [Q_AW-1:0]  q_rp_q;
  logic [Q_CW-1:0]  q_cnt_q;
  logic             push;
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= OUTER_RST;
      inner_q <= INNER_RST;
      gain_q  <= GAIN_RST;
      shift_q <= SHIFT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OUTER: outer_q <= cfg_wdata_i[OUTER_W-1:0];
        CFG_INNER: inner_q <= cfg_wdata_i[INNER_W-1:0];
        CFG_GAIN:  gain_q  <= cfg_wdata_i[GAIN_W-1:0];
        CFG_SHIFT: shift_q <= cfg_wdata_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (outer_q < OUTER_W'(MIN_OUTER)) begin
      o_eff = OW'(MIN_OUTER);
    end else if (outer_q > OUTER_W'(OUTER_CAP)) begin
      o_eff = OW'(OUTER_CAP);
    end else begin
      o_eff = OW'(outer_q);
    end
    o_less = CW'(o_eff) - CW'(1);
    if (CW'(inner_q) > o_less) begin
      i_eff = INNER_W'(o_less);
    end else begin
      i_eff = inner_q;
    end
  end

  assign wp_nx  = (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign fsp_nx = (fsp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : fsp_q + 1'b1;

  assign can_issue = (q_cnt_q + Q_CW'(iss_q) + Q_CW'(res_v)) < Q_CW'(Q_DEPTH);
  assign in_stall_o = flush_q | ~can_issue;
  assign acc   = in_valid_i & ~in_stall_o;
  assign iss_v = acc | (flush_q & can_issue);

  always_comb begin
    if (flush_q) begin
      iss_pos      = fm_q;
      iss_ptr      = fsp_q;
      iss_ahead    = fj_q;
      iss_pix      = '0;
      iss_ctl.last = (fj_q == o_eff);
      iss_ctl.emit = (fm_q >= (POS_W + 1)'(o_eff));
    end else begin
      iss_pos      = {1'b0, cnt_q};
      iss_ptr      = wp_q;
      iss_ahead    = '0;
      iss_pix      = pixel_in_i;
      iss_ctl.last = 1'b0;
      iss_ctl.emit = (cnt_q >= POS_W'(o_eff));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      wp_q    <= '0;
      flush_q <= 1'b0;
      fj_q    <= '0;
      fm_q    <= '0;
      fsp_q   <= '0;
      iss_q   <= 1'b0;
    end else begin
      iss_q <= iss_v;
      if (acc) begin
        if (row_end_i) begin
          cnt_q   <= '0;
          wp_q    <= '0;
          flush_q <= 1'b1;
          fj_q    <= OW'(1);
          fm_q    <= {1'b0, cnt_q} + 1'b1;
          fsp_q   <= wp_nx;
        end else begin
          cnt_q <= (cnt_q == '1) ? POS_W'(FOLD_BASE) : cnt_q + 1'b1;
          wp_q  <= wp_nx;
        end
      end else if (flush_q && can_issue) begin
        fj_q  <= fj_q + 1'b1;
        fm_q  <= fm_q + 1'b1;
        fsp_q <= fsp_nx;
        if (fj_q == o_eff) begin
          flush_q <= 1'b0;
        end
      end
    end
  end

  bprf_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .OUTER_CAP    (OUTER_CAP)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (acc),
    .wr_addr_i   (wp_q),
    .wr_data_i   (pixel_in_i),
    .iss_valid_i (iss_v),
    .iss_ctl_i   (iss_ctl),
    .iss_pos_i   (iss_pos),
    .iss_ptr_i   (iss_ptr),
    .iss_ahead_i (iss_ahead),
    .iss_pix_i   (iss_pix),
    .outer_i     (o_eff),
    .inner_i     (i_eff),
    .gain_i      (gain_q),
    .res_valid_o (res_v),
    .res_ctl_o   (res_ctl),
    .res_sum_o   (res_sum)
  );

  always_comb begin
    lvl_sh = $signed(lvl_q) >>> shift_q;
    if (lvl_sh[ACC_WIDTH-1]) begin
      sat = '0;
    end else if (|lvl_sh[ACC_WIDTH-2:PIX_W]) begin
      sat = '1;
    end else begin
      sat = lvl_sh[PIX_W-1:0];
    end
  end

  // Accumulate each step's tap sum; drop the row state on its last step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q   <= '0;
      slope_q <= '0;
      curve_q <= '0;
    end else if (res_v) begin
      if (res_ctl.last) begin
        lvl_q   <= '0;
        slope_q <= '0;
        curve_q <= '0;
      end else begin
        lvl_q   <= lvl_q + slope_q;
        slope_q <= slope_q + curve_q;
        curve_q <= curve_q + {{(ACC_WIDTH - DSUM_W){res_sum[DSUM_W-1]}}, res_sum};
      end
    end
  end

  assign push = res_v & res_ctl.emit;
  assign pop  = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_pix_q[q_wp_q]  <= sat;
      q_last_q[q_wp_q] <= res_ctl.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wp_q  <= '0;
      q_rp_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (push) begin
        q_wp_q <= q_wp_q + 1'b1;
      end
      if (pop) begin
        q_rp_q <= q_rp_q + 1'b1;
      end
      q_cnt_q <= q_cnt_q + Q_CW'(push) - Q_CW'(pop);
    end
  end

  assign out_valid_o = (q_cnt_q != '0);
  assign pixel_out_o = q_pix_q[q_rp_q];
  assign row_last_o  = q_last_q[q_rp_q];

endmodule
